FILE: src/amrht_pkg.sv
// Package for the mesh cell hash table: item types, operation, status and
// register codes, and default sizes. No dependencies.
package amrht_pkg;

  // Default sizes handed to the top level's parameters.
  localparam int unsigned DEF_TABLE_SIZE  = 1024;
  localparam int unsigned DEF_BUCKET_WAYS = 4;
  localparam int unsigned DEF_COORD_BITS  = 16;
  localparam int unsigned DEF_HANDLE_BITS = 16;

  // Fixed field widths.
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned COLS_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned COUNT_W    = 13;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_LEVEL_HIGH = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FINEST_LEVEL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINEST_COLUMNS = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        cell_x;
    logic [15:0]        cell_y;
    logic [LEVEL_W-1:0] cell_level;
    logic [15:0]        cell_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        found_handle;
    logic [COUNT_W-1:0] cell_count;
  } out_item_t;

endpackage

FILE: src/amr_cell_hash_table.sv
// Sequence per accepted item: four modular reductions on one shared multiplier, each through the
// LOAD, QUO, REM and FIX states, then an address state, a read and a compare per way read
// (1..BUCKET_WAYS), and the output state. Level errors and unused ops go straight to the output
// state. While an earlier result is still stalled at the output, the item waits in the output state.
// One item at a time: the input stays stalled until the item's result has been sent.
// After reset a clearing pass writes every way invalid, input stalled.
module amr_cell_hash_table
  import amrht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE  = DEF_TABLE_SIZE,
  parameter int unsigned BUCKET_WAYS = DEF_BUCKET_WAYS,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS,
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned TOTAL  = TABLE_SIZE * BUCKET_WAYS;
  localparam int unsigned AW     = $clog2(TOTAL);
  localparam int unsigned RW     = $clog2(TABLE_SIZE);
  localparam int unsigned WW     = $clog2(BUCKET_WAYS + 1);
  localparam int unsigned CW     = $clog2(TOTAL + 1);
  localparam logic [RW:0] TMOD   = (RW + 1)'(TABLE_SIZE);
  localparam logic [31:0] TSIZE  = 32'(TABLE_SIZE);
  localparam logic [31:0] RECIP  = 32'(64'h1_0000_0000 / 64'(TABLE_SIZE));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_QUO  = 4'd3;
  localparam logic [3:0] S_REM  = 4'd4;
  localparam logic [3:0] S_FIX  = 4'd5;
  localparam logic [3:0] S_ADDR = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // Reduction steps: x, y, the column key, then the level scaling.
  localparam logic [1:0] STEP_X     = 2'd0;
  localparam logic [1:0] STEP_Y     = 2'd1;
  localparam logic [1:0] STEP_KEY   = 2'd2;
  localparam logic [1:0] STEP_SCALE = 2'd3;

  typedef struct packed {
    logic                   valid;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [LEVEL_W-1:0]     level;
    logic [HANDLE_BITS-1:0] handle;
  } way_t;

  // Way store.
  way_t mem [TOTAL];
  way_t rd_r;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  way_t mem_wdata;

  // Control and item registers.
  logic [3:0]             state_r, state_nxt;
  logic [LEVEL_W-1:0]     lvl_cfg_r, lvl_cfg_nxt;
  logic [COLS_W-1:0]      cols_r, cols_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [COORD_BITS-1:0]  x_r, x_nxt;
  logic [COORD_BITS-1:0]  y_r, y_nxt;
  logic [LEVEL_W-1:0]     lvl_r, lvl_nxt;
  logic [HANDLE_BITS-1:0] hdl_r, hdl_nxt;
  logic [1:0]             step_r, step_nxt;
  logic [31:0]            v_r, v_nxt;
  logic [31:0]            q_r, q_nxt;
  logic [RW:0]            rest_r, rest_nxt;
  logic [RW-1:0]          xm_r, xm_nxt;
  logic [RW-1:0]          rem_r, rem_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [WW-1:0]          way_r, way_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [HANDLE_BITS-1:0] found_r, found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           mul_p;
  logic [RW:0]           rest_fix;
  logic                  hit;
  logic                  key_match;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic [LEVEL_W-1:0]    shift_amt;

  // The remainder estimate lies below twice the table size, so one subtraction finishes it.
  assign rest_fix  = (rest_r >= TMOD) ? (rest_r - TMOD) : rest_r;
  assign key_match = rd_r.valid && (rd_r.x == x_r) && (rd_r.y == y_r) && (rd_r.level == lvl_r);
  assign hit       = (op_r == OP_INSERT) ? !rd_r.valid : key_match;
  assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_r};
  assign shift_amt = lvl_cfg_r - lvl_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared multiplier: reciprocal estimate of the quotient, quotient times the table size,
  // and the column product of the key.
  always_comb begin
    mul_a = v_r;
    mul_b = RECIP;
    if (state_r == S_REM) begin
      mul_a = q_r;
      mul_b = TSIZE;
    end else if (state_r == S_LOAD) begin
      mul_a = 32'(cols_r);
      mul_b = 32'(rem_r);
    end
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Memory write select: clearing pass or the way chosen by a scan.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = rd_r;
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r;
      mem_wdata = '0;
    end else if (state_r == S_CMP && hit && op_r != OP_SEARCH) begin
      mem_we = 1'b1;
      if (op_r == OP_INSERT) begin
        mem_wdata = '{valid: 1'b1, x: x_r, y: y_r, level: lvl_r, handle: hdl_r};
      end else begin
        mem_wdata.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[addr_r];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    lvl_cfg_nxt   = lvl_cfg_r;
    cols_nxt      = cols_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    lvl_nxt       = lvl_r;
    hdl_nxt       = hdl_r;
    step_nxt      = step_r;
    v_nxt         = v_r;
    q_nxt         = q_r;
    rest_nxt      = rest_r;
    xm_nxt        = xm_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    way_nxt       = way_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    // Configuration writes.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FINEST_LEVEL:   lvl_cfg_nxt = cfg_wdata[LEVEL_W-1:0];
        CFG_FINEST_COLUMNS: cols_nxt    = cfg_wdata[COLS_W-1:0];
        default:            ;
      endcase
    end

    unique case (state_r)
      S_CLR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(TOTAL - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.op;
          x_nxt      = COORD_BITS'(in_data.cell_x);
          y_nxt      = COORD_BITS'(in_data.cell_y);
          lvl_nxt    = in_data.cell_level;
          hdl_nxt    = HANDLE_BITS'(in_data.cell_handle);
          found_nxt  = '0;
          status_nxt = ST_NOT_FOUND;
          step_nxt   = STEP_X;
          if (in_data.cell_level > lvl_cfg_r) begin
            status_nxt = ST_LEVEL_HIGH;
            state_nxt  = S_OUT;
          end else if (in_data.op != OP_INSERT && in_data.op != OP_REMOVE &&
                       in_data.op != OP_SEARCH) begin
            state_nxt = S_OUT;
          end else begin
            if (in_data.op == OP_INSERT) begin
              status_nxt = ST_FULL;
            end
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        // Each value fits 32 bits because x, y and the key are reduced before they grow.
        case (step_r)
          STEP_X:     v_nxt = 32'(x_r);
          STEP_Y:     v_nxt = 32'(y_r);
          STEP_KEY:   v_nxt = mul_p[31:0] + 32'(xm_r);
          STEP_SCALE: v_nxt = 32'(rem_r) << shift_amt;
        endcase
        state_nxt = S_QUO;
      end
      S_QUO: begin
        // Quotient estimate, at most one below the true quotient.
        q_nxt     = mul_p[63:32];
        state_nxt = S_REM;
      end
      S_REM: begin
        rest_nxt  = v_r[RW:0] - mul_p[RW:0];
        state_nxt = S_FIX;
      end
      S_FIX: begin
        rem_nxt = rest_fix[RW-1:0];
        if (step_r == STEP_X) begin
          xm_nxt = rest_fix[RW-1:0];
        end
        if (step_r == STEP_SCALE) begin
          state_nxt = S_ADDR;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_ADDR: begin
        addr_nxt  = AW'(rem_r) * AW'(BUCKET_WAYS);
        way_nxt   = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          status_nxt = ST_DONE;
          state_nxt  = S_OUT;
          case (op_r)
            OP_INSERT: cnt_nxt = cnt_r + 1'b1;
            OP_REMOVE: begin
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            default:   found_nxt = rd_r.handle;
          endcase
        end else if (way_r == WW'(BUCKET_WAYS - 1)) begin
          state_nxt = S_OUT;
        end else begin
          way_nxt   = way_r + 1'b1;
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: status_r, found_handle: 16'(found_r),
                            cell_count: cnt_ext[COUNT_W-1:0]};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Registers; reset starts the clearing pass and sets the control state; item registers are not reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      cnt_r       <= '0;
      lvl_cfg_r   <= '0;
      cols_r      <= COLS_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      lvl_cfg_r   <= lvl_cfg_nxt;
      cols_r      <= cols_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    lvl_r      <= lvl_nxt;
    hdl_r      <= hdl_nxt;
    step_r     <= step_nxt;
    v_r        <= v_nxt;
    q_r        <= q_nxt;
    rest_r     <= rest_nxt;
    xm_r       <= xm_nxt;
    rem_r      <= rem_nxt;
    way_r      <= way_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: src/amrht_checker.sv
// Port-level checks for the mesh cell hash table, bound to the top level.
// Depends on amrht_pkg for the item types and status codes.
module amrht_checker
  import amrht_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Reset starts the clearing pass, so input is stalled right after it.
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // One item at a time: an accepted item stalls the input next cycle.
  a_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only a successful operation may report a handle.
  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |-> out_data.found_handle == 16'd0)
    else $error("handle reported on failure");

endmodule

bind amr_cell_hash_table amrht_checker u_amrht_checker (.*);
